@@ hw/rtl/csh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_pkg: shared types and functions for the string hash block
// CRC-32 byte update, multiply-by-101 update and the input item layout.
// ----------------------------------------------------------------------------
package csh_pkg;

  localparam logic [31:0] CrcPolyRefl = 32'hEDB88320;
  localparam logic [31:0] CrcInit     = 32'hFFFFFFFF;
  localparam logic [31:0] CrcXorOut   = 32'hFFFFFFFF;
  localparam logic [31:0] MultSeed    = 32'h00000000;

  localparam int unsigned ByteW = 8;
  localparam int unsigned HashW = 64;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             last;
  } item_t;

  // reflected crc-32 over one byte, one bit per step
  function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                           input logic [ByteW-1:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPolyRefl & {32{c[0]}});
    end
    return c;
  endfunction

  // h*101 + sext(b), 101 = 64 + 32 + 4 + 1
  function automatic logic [31:0] mult_step(input logic [31:0] h,
                                            input logic [ByteW-1:0] b);
    logic [31:0] sb;
    sb = {{24{b[7]}}, b};
    return (h << 6) + (h << 5) + (h << 2) + h + sb;
  endfunction

endpackage

@@ hw/rtl/csh_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_in_stage: input register
// Captures one beat from the slave side and holds it until the core takes it.
// ----------------------------------------------------------------------------
module csh_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [7:0]              s_axis_tdata_i,  // data_byte
  input  logic                    s_axis_tuser_i,  // has_byte
  input  logic                    s_axis_tlast_i,
  input  logic                    advance_i,
  output logic                    valid_o,
  output csh_pkg::item_t          item_o
);
  import csh_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d = 1'b1;
      item_d  = '{data_byte: s_axis_tdata_i, has_byte: s_axis_tuser_i,
                  last: s_axis_tlast_i};
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/csh_hash_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_hash_core: running hash state
// Folds one byte into the crc and the multiplicative hash, gives the final
// 64-bit value and restarts on the last beat of a string.
// ----------------------------------------------------------------------------
module csh_hash_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  csh_pkg::item_t            item_i,
  output logic [csh_pkg::HashW-1:0] hash_o
);
  import csh_pkg::*;

  logic [31:0] crc_q, crc_d, crc_upd;
  logic [31:0] mult_q, mult_d, mult_upd;
  logic        zero_q, zero_d, zero_upd;

  always_comb begin
    crc_upd  = crc_q;
    mult_upd = mult_q;
    zero_upd = zero_q;
    if (item_i.has_byte) begin
      crc_upd = crc_byte(crc_q, item_i.data_byte);
      if (!zero_q) begin
        // a zero byte freezes the multiplicative hash for the rest of the string
        if (item_i.data_byte == '0) begin
          zero_upd = 1'b1;
        end else begin
          mult_upd = mult_step(mult_q, item_i.data_byte);
        end
      end
    end
  end

  assign hash_o = {crc_upd ^ CrcXorOut, mult_upd};

  always_comb begin
    crc_d  = crc_q;
    mult_d = mult_q;
    zero_d = zero_q;
    if (fire_i) begin
      if (item_i.last) begin
        crc_d  = CrcInit;
        mult_d = MultSeed;
        zero_d = 1'b0;
      end else begin
        crc_d  = crc_upd;
        mult_d = mult_upd;
        zero_d = zero_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      mult_q <= MultSeed;
      zero_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      mult_q <= mult_d;
      zero_q <= zero_d;
    end
  end

endmodule

@@ hw/rtl/csh_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_out_stage: result register
// Holds one finished hash until the master side takes it.
// ----------------------------------------------------------------------------
module csh_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [csh_pkg::HashW-1:0] hash_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [csh_pkg::HashW-1:0] m_axis_tdata_o   // hash_value
);
  import csh_pkg::*;

  logic             valid_q, valid_d;
  logic [HashW-1:0] data_q, data_d;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = hash_i;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

@@ hw/rtl/crc32_mul101_string_hash64.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_mul101_string_hash64: 64-bit string hash
// Bits 63:32 reflected crc-32 of all bytes, bits 31:0 hash*101+byte up to
// the first zero byte; one hash per string, given on its last beat.
//
//   channel   dir  tdata          tuser      tlast
//   s_axis    in   data_byte[7:0] has_byte   last of string
//   m_axis    out  hash_value     -          -
//
// one beat a cycle on the input; a beat waits in the input register and
// is folded in as it leaves it, and a string's hash is then offered from
// the result register, which frees in the same cycle it is taken, so the
// input only stalls while a finished hash waits and a last beat is queued
// behind it. reset puts the crc to all ones and the hash to zero.
// ----------------------------------------------------------------------------
module crc32_mul101_string_hash64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // hash_value
);
  import csh_pkg::*;

  item_t            item;
  logic             item_valid;
  logic             out_free;
  logic             advance;
  logic [HashW-1:0] hash;

  // non-last beats never need the result register
  assign advance = item_valid && (!item.last || out_free);

  csh_in_stage u_in (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  csh_hash_core u_core (
    .clk_i,
    .rst_ni,
    .fire_i (advance),
    .item_i (item),
    .hash_o (hash)
  );

  csh_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i (advance && item.last),
    .hash_i (hash),
    .free_o (out_free),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for crc32_mul101_string_hash64
// Streams strings a byte per beat and checks every 64-bit hash. The expected
// hash comes from a bitwise crc-32 and a multiply-by-101 hash kept in a
// small scoreboard. Both stream sides idle at random, the output side once
// holds off long enough to back up the input, and the sender once drains.
// ----------------------------------------------------------------------------
module testbench;
  import csh_pkg::*;

  localparam logic [31:0] MulFactor  = 32'd101;
  localparam int unsigned RandItems  = 1800;
  localparam int unsigned StuckLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // data_byte
  logic        s_axis_tuser_i;   // has_byte
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;   // hash_value

  class hash_scoreboard;
    logic [31:0] crc_acc;
    logic [31:0] mult_acc;
    bit          zero_hit;
    logic [63:0] expected_hashes[$];
    int unsigned mismatches;

    function new();
      restart_string();
      mismatches = 0;
    endfunction

    function void restart_string();
      crc_acc  = CrcInit;
      mult_acc = MultSeed;
      zero_hit = 1'b0;
    endfunction

    // fold one input beat into the running hashes
    function void note_beat(logic [7:0] b, logic hb, logic lst);
      logic fb;
      if (hb) begin
        for (int i = 0; i < 8; i++) begin
          fb = crc_acc[0] ^ b[i];
          crc_acc = {1'b0, crc_acc[31:1]} ^ (fb ? CrcPolyRefl : 32'h0);
        end
        if (!zero_hit) begin
          if (b == 8'h00) zero_hit = 1'b1;
          else mult_acc = mult_acc * MulFactor + {{24{b[7]}}, b};
        end
      end
      if (lst) begin
        expected_hashes.push_back({crc_acc ^ CrcXorOut, mult_acc});
        restart_string();
      end
    endfunction

    function void check_hash(logic [63:0] got);
      logic [63:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: no hash expected, got %h", got);
        mismatches++;
      end else begin
        want = expected_hashes.pop_front();
        if (got !== want) begin
          $error("hash_value: expected %h, got %h", want, got);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction
  endclass

  hash_scoreboard hashes = new();

  int unsigned item_count = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_rx = 1'b0;

  crc32_mul101_string_hash64 u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // beat monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      hashes.note_beat(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      hashes.check_hash(m_axis_tdata_o);
    end
  end

  // output side: random backpressure, one long hold-off on request
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      m_axis_tready_i <= quiet_phase || ($urandom_range(99) >= 29);
    end
  end

  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
    while (!quiet_phase && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= hb;
    s_axis_tlast_i  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (hb || lst) item_count++;
  endtask

  task automatic wait_drained();
    while (hashes.pending() != 0) @(posedge clk_i);
  endtask

  // random string, ended either on its last byte or by a byteless beat
  task automatic send_random_string(input int unsigned max_len);
    int unsigned len;
    bit          tail_end;
    logic [7:0]  b;
    len = $urandom_range(max_len);
    tail_end = (len == 0) || ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      b = ($urandom_range(11) == 0) ? 8'h00 : 8'($urandom_range(255));
      send_beat(b, 1'b1, !tail_end && (i == len - 1));
    end
    if (tail_end) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    bit pressure_done;
    bit drain_done;
    pressure_done = 1'b0;
    drain_done = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tuser_i  <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty string, then a bare beat that must change nothing
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b1);
    // crc check string "123456789"
    for (int i = 1; i <= 9; i++) send_beat(8'h30 + 8'(i), 1'b1, i == 9);
    send_beat(8'hff, 1'b1, 1'b1);
    // sign extension edges, ended by a byteless beat
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h7f, 1'b1, 1'b0);
    send_beat(8'h3c, 1'b0, 1'b1);
    // zero byte freezes the multiplicative hash only
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h41, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);

    item_count = 0;
    while (item_count < RandItems) begin
      quiet_phase = (item_count >= 900) && (item_count < 1150);
      if (!pressure_done && item_count > 600) begin
        // short strings pile up while the output side holds off
        hold_rx = 1'b1;
        repeat (30) send_random_string(2);
        pressure_done = 1'b1;
      end
      if (!drain_done && item_count > 1300) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
        drain_done = 1'b1;
      end
      send_random_string(($urandom_range(9) == 0) ? 64 : 16);
    end
    quiet_phase = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (hashes.mismatches == 0 && hashes.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
